// ===== design/hhc_pkg.sv =====
// shared types and constants for the hysteresis heater controller
package hhc_pkg;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		CFG_SETPOINT     = 3'd0,
		CFG_HYSTERESIS   = 3'd1,
		CFG_FREEZE_LIMIT = 3'd2,
		CFG_MIN_SWITCH   = 3'd3,
		CFG_MAINT_DAYS   = 3'd4
	} cfg_idx_t;

	localparam int CFG_DATA_W  = 17;
	localparam int TEMP_W      = 15;
	localparam int TIME_W      = 32;
	localparam int HYST_W      = 11;
	localparam int MIN_SW_W    = 17;
	localparam int DAYS_W      = 9;
	localparam int SETTLE_W    = 19;
	localparam int MAINT_LIM_W = 26;

	localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;

	// actuator state codes
	localparam logic [1:0] HEATER_OFF   = 2'd0;
	localparam logic [1:0] HEATER_ON    = 2'd1;
	localparam logic [1:0] HEATER_UNDET = 2'd2;

	// sample count saturates here
	localparam logic [1:0] SEEN_FULL = 2'd2;

	// register reset values
	localparam logic signed [14:0] TARGET_RST    = 15'sd2100;
	localparam logic [10:0]        HYST_RST      = 11'd50;
	localparam logic signed [14:0] FREEZE_RST    = 15'sd500;
	localparam logic [16:0]        MIN_SW_RST    = 17'd300;
	localparam logic [8:0]         DAYS_RST      = 9'd7;
	localparam logic [18:0]        SETTLE_RST    = 19'd900;
	localparam logic [25:0]        MAINT_LIM_RST = 26'd604800;

	// configuration as seen by the decision logic
	typedef struct packed {
		logic signed [14:0] setpoint;
		logic [10:0]        hysteresis;
		logic signed [14:0] freeze_limit;
		logic [16:0]        min_switch;
		logic [18:0]        settle_time;
		logic [25:0]        maint_limit;
	} cfg_t;

	// one result word
	typedef struct packed {
		logic [1:0] actuator_state;
		logic       changed;
		logic       maint;
	} res_t;

endpackage

// ===== design/hhc_cfg.sv =====
// configuration registers with precomputed time limits
module hhc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [2:0]                    cfg_index,
	input  logic [hhc_pkg::CFG_DATA_W-1:0] cfg_data,
	output hhc_pkg::cfg_t                 cfg
);

	logic signed [14:0] target_q;
	logic [10:0]        hyst_q;
	logic signed [14:0] freeze_q;
	logic [16:0]        min_sw_q;
	logic [18:0]        settle_q;
	logic [25:0]        maint_lim_q;
	logic [25:0]        maint_lim_d;
	logic [18:0]        settle_d;

	// derived limits: days in seconds and three switch intervals
	always_comb begin
		maint_lim_d = {17'd0, cfg_data[8:0]} * {9'd0, hhc_pkg::SECONDS_PER_DAY};
		settle_d    = {1'b0, cfg_data, 1'b0} + {2'b00, cfg_data};
	end

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= hhc_pkg::TARGET_RST;
			hyst_q      <= hhc_pkg::HYST_RST;
			freeze_q    <= hhc_pkg::FREEZE_RST;
			min_sw_q    <= hhc_pkg::MIN_SW_RST;
			settle_q    <= hhc_pkg::SETTLE_RST;
			maint_lim_q <= hhc_pkg::MAINT_LIM_RST;
		end else if (cfg_valid) begin
			unique case (hhc_pkg::cfg_idx_t'(cfg_index))
				hhc_pkg::CFG_SETPOINT: begin
					target_q <= $signed(cfg_data[14:0]);
				end
				hhc_pkg::CFG_HYSTERESIS: begin
					hyst_q <= cfg_data[10:0];
				end
				hhc_pkg::CFG_FREEZE_LIMIT: begin
					freeze_q <= $signed(cfg_data[14:0]);
				end
				hhc_pkg::CFG_MIN_SWITCH: begin
					min_sw_q <= cfg_data;
					settle_q <= settle_d;
				end
				hhc_pkg::CFG_MAINT_DAYS: begin
					maint_lim_q <= maint_lim_d;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.setpoint     = target_q;
		cfg.hysteresis   = hyst_q;
		cfg.freeze_limit = freeze_q;
		cfg.min_switch   = min_sw_q;
		cfg.settle_time  = settle_q;
		cfg.maint_limit  = maint_lim_q;
	end

endmodule

// ===== design/hhc_core.sv =====
// thermostat and maintenance decision with its state registers
module hhc_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic signed [14:0]     temperature,
	input  logic [31:0]            timestamp,
	input  hhc_pkg::cfg_t          cfg,
	output hhc_pkg::res_t          res
);

	logic signed [14:0] latest_q;
	logic [1:0]         seen_q;
	logic [1:0]         heater_q;
	logic [31:0]        lct_q;
	logic               maint_q;
	logic [31:0]        mstart_q;

	logic signed [15:0] prev_x, cur_x, fz_x, low_band, high_band;
	logic               two_seen;
	logic               req_a, force_a, want_a, sw_a;
	logic [31:0]        elapsed_a, elapsed_b, maint_elapsed;
	logic [1:0]         heater_a, heater_d;
	logic [31:0]        lct_a, lct_d;
	logic               req_b, want_b, sw_b;
	logic               maint_d, maint_start;

	// thermostat request from the two most recent samples
	always_comb begin
		prev_x    = $signed({latest_q[14], latest_q});
		cur_x     = $signed({temperature[14], temperature});
		fz_x      = $signed({cfg.freeze_limit[14], cfg.freeze_limit});
		low_band  = $signed({cfg.setpoint[14], cfg.setpoint})
			- $signed({5'b00000, cfg.hysteresis});
		high_band = $signed({cfg.setpoint[14], cfg.setpoint})
			+ $signed({5'b00000, cfg.hysteresis});
		two_seen  = (seen_q != 2'd0);
		req_a     = 1'b0;
		force_a   = 1'b0;
		want_a    = 1'b0;
		if (two_seen) begin
			priority if (prev_x < fz_x && cur_x < fz_x) begin
				req_a   = 1'b1;
				force_a = 1'b1;
				want_a  = 1'b1;
			end else if (prev_x < low_band && cur_x < low_band) begin
				req_a  = 1'b1;
				want_a = 1'b1;
			end else if (prev_x > high_band && cur_x > high_band) begin
				req_a = 1'b1;
			end
		end
		elapsed_a = timestamp - lct_q;
		sw_a = req_a && (force_a || elapsed_a >= {15'd0, cfg.min_switch})
			&& ({1'b0, want_a} != heater_q);
		heater_a = sw_a ? {1'b0, want_a} : heater_q;
		lct_a    = sw_a ? timestamp : lct_q;
	end

	// maintenance cycle start and end, acting on the updated state
	always_comb begin
		elapsed_b     = timestamp - lct_a;
		maint_elapsed = timestamp - mstart_q;
		maint_start   = 1'b0;
		maint_d       = maint_q;
		req_b         = 1'b0;
		want_b        = 1'b0;
		if (!maint_q) begin
			if (elapsed_b > {6'd0, cfg.maint_limit}) begin
				maint_start = 1'b1;
				maint_d     = 1'b1;
				req_b       = 1'b1;
				want_b      = 1'b1;
			end
		end else if (maint_elapsed > {13'd0, cfg.settle_time} && two_seen
				&& prev_x > fz_x && cur_x > fz_x) begin
			maint_d = 1'b0;
			req_b   = 1'b1;
		end
		sw_b = req_b && (elapsed_b >= {15'd0, cfg.min_switch})
			&& ({1'b0, want_b} != heater_a);
		heater_d = sw_b ? {1'b0, want_b} : heater_a;
		lct_d    = sw_b ? timestamp : lct_a;

		res.actuator_state = heater_d;
		res.changed        = sw_a | sw_b;
		res.maint          = maint_d;
	end

	// state update once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q <= '0;
			seen_q   <= '0;
			heater_q <= hhc_pkg::HEATER_UNDET;
			lct_q    <= '0;
			maint_q  <= 1'b0;
			mstart_q <= '0;
		end else if (en) begin
			latest_q <= temperature;
			if (seen_q != hhc_pkg::SEEN_FULL) begin
				seen_q <= seen_q + 2'd1;
			end
			heater_q <= heater_d;
			lct_q    <= lct_d;
			maint_q  <= maint_d;
			if (maint_start) begin
				mstart_q <= timestamp;
			end
		end
	end

`ifndef SYNTH
	a_heater_code: assert property (@(posedge clk) disable iff (!arst_n)
		heater_q == hhc_pkg::HEATER_OFF || heater_q == hhc_pkg::HEATER_ON
		|| heater_q == hhc_pkg::HEATER_UNDET)
		else $error("heater state holds an unused code");
	a_no_undet_return: assert property (@(posedge clk) disable iff (!arst_n)
		heater_q != hhc_pkg::HEATER_UNDET |=> heater_q != hhc_pkg::HEATER_UNDET)
		else $error("heater state went back to undetermined");
	a_lct_only_on_switch: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && res.changed) |=> $stable(lct_q))
		else $error("last change time moved without a switch");
	a_maint_start_time: assert property (@(posedge clk) disable iff (!arst_n)
		en && maint_start |=> mstart_q == $past(timestamp) && maint_q)
		else $error("maintenance start not recorded");
`endif

endmodule

// ===== design/hysteresis_heater_control.sv =====
// top level of the hysteresis heater controller
//
// Sample channel: temperature (signed hundredths of a degree) and timestamp
// (seconds, wrapping) are taken on a rising edge with sample_valid high and
// sample_stall low. Each sample gives exactly one result word on the result
// channel: actuator_state, actuator_changed and maintenance_active, taken on
// an edge with result_valid high and result_stall low.
// The sample is registered at acceptance, the decision logic runs between
// that register and the result register, and the result is shown once it
// is in the result register. One word per cycle is sustained while
// result_stall stays low; the only limit is the single decision stage.
// When the receiver stalls, the result register holds its word and the
// input register keeps one more sample; sample_stall rises once both are
// full. Configuration writes (cfg_index, cfg_data) are always taken
// (cfg_ready high) and apply to the next sample decided.
// Reset loads the register defaults, clears both pipeline stages and sets
// the actuator state to undetermined.
module hysteresis_heater_control (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [14:0]             temperature,
	input  logic [31:0]                    timestamp,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [1:0]                     actuator_state,
	output logic                           actuator_changed,
	output logic                           maintenance_active,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [2:0]                     cfg_index,
	input  logic [hhc_pkg::CFG_DATA_W-1:0] cfg_data
);

	hhc_pkg::cfg_t      cfg;
	hhc_pkg::res_t      res;
	logic               valid_s1;
	logic signed [14:0] temp_s1;
	logic [31:0]        ts_s1;
	logic               valid_s2;
	hhc_pkg::res_t      res_s2;
	logic               out_free;
	logic               adv_s1;
	logic               take_in;

	assign cfg_ready = 1'b1;

	hhc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake between the two stages
	always_comb begin
		out_free     = !valid_s2 || !result_stall;
		adv_s1       = valid_s1 && out_free;
		sample_stall = valid_s1 && !out_free;
		take_in      = sample_valid && !sample_stall;
	end

	hhc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv_s1),
		.temperature (temp_s1),
		.timestamp   (ts_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				valid_s2 <= adv_s1;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (take_in) begin
			temp_s1 <= temperature;
			ts_s1   <= timestamp;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	always_comb begin
		result_valid       = valid_s2;
		actuator_state     = res_s2.actuator_state;
		actuator_changed   = res_s2.changed;
		maintenance_active = res_s2.maint;
	end

`ifndef SYNTH
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && valid_s2 && result_stall)
		else $error("sample stalled with room in the pipeline");
	a_decided_word_shown: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("decided word lost before the result register");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(res_s2))
		else $error("stalled result word changed");
`endif

endmodule
